// ===== hdl/iec_pkg.sv =====
// ============================================================================
// iec_pkg: shared types and constants of the expression calculator
// Character codes, operation kinds, status codes, parser phases, arithmetic
// unit states and the queue status record used between the front and back.
// ============================================================================
package iec_pkg;

    localparam int CHAR_W      = 8;
    localparam int SEEN_W      = 6;
    localparam int RESULT_W    = 32;
    localparam int STATUS_W    = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_OP   = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_BAD = 3'd4
    } op_t;

    localparam int OP_W = 3;

    typedef enum logic [2:0] {
        PH_LEAD1 = 3'd0,
        PH_DIG1  = 3'd1,
        PH_GAP   = 3'd2,
        PH_LEAD2 = 3'd3,
        PH_DIG2  = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE = 3'd0,
        BK_MUL  = 3'd1,
        BK_DIV  = 3'd2,
        BK_FIX  = 3'd3,
        BK_DONE = 3'd4
    } bk_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ===== hdl/iec_queue.sv =====
// ============================================================================
// iec_queue: two-entry job queue
// Holds parsed lines between the parser and the arithmetic unit so that
// each side can stall on its own.
// ============================================================================
module iec_queue #(
    parameter int WIDTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [WIDTH-1:0]   push_data,
    input  logic               pop,
    output logic [WIDTH-1:0]   pop_data,
    output iec_pkg::qstat_t    qstat
);
    import iec_pkg::*;

    logic [WIDTH-1:0]  mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data    = mem_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

endmodule

// ===== hdl/iec_front.sv =====
// ============================================================================
// iec_front: line parser
// Takes one character per cycle unless the queue is full, builds the two
// operands and the operator; end-of-line queues one job and starts a new line.
// ============================================================================
module iec_front #(
    parameter int LINE_LIMIT  = 60,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [iec_pkg::CHAR_W-1:0]          s_tdata,  // [7:0] char_code
    input  logic                                s_tlast,  // end_of_line
    input  iec_pkg::qstat_t                     qstat,
    output logic                                push,
    output iec_pkg::op_t                        job_op,
    output logic [VALUE_WIDTH-1:0]              job_a,
    output logic [VALUE_WIDTH-1:0]              job_b
);
    import iec_pkg::*;

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [VALUE_WIDTH-1:0]  first_reg;
    logic [VALUE_WIDTH-1:0]  first_next;
    logic [VALUE_WIDTH-1:0]  acc_reg;
    logic [VALUE_WIDTH-1:0]  acc_next;
    logic                    neg_reg;
    logic                    neg_next;
    logic [CHAR_W-1:0]       opc_reg;
    logic [CHAR_W-1:0]       opc_next;
    logic [SEEN_W-1:0]       seen_reg;
    logic [SEEN_W-1:0]       seen_next;

    logic                    accept;
    logic                    is_digit;
    logic [VALUE_WIDTH-1:0]  acc_x10;
    logic [VALUE_WIDTH-1:0]  acc_signed;
    logic [VALUE_WIDTH-1:0]  acc_signed_next;

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;
    assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign acc_x10  = (acc_reg << 3) + (acc_reg << 1)
                    + {{(VALUE_WIDTH-4){1'b0}}, s_tdata[3:0]};
    assign acc_signed = neg_reg ? ({VALUE_WIDTH{1'b0}} - acc_reg) : acc_reg;

    always_comb
    begin
        phase_next = phase_reg;
        first_next = first_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        opc_next   = opc_reg;
        seen_next  = seen_reg;
        push       = 1'b0;
        job_op     = OP_BAD;
        job_a      = first_reg;
        job_b      = '0;
        acc_signed_next = '0;

        if (accept && (seen_reg < SEEN_W'(LINE_LIMIT)))
        begin
            seen_next = seen_reg + 1'b1;
            case (phase_reg)
                PH_LEAD1, PH_DIG1:
                begin
                    if (s_tdata == CH_NUL)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (is_digit)
                    begin
                        acc_next   = acc_x10;
                        phase_next = PH_DIG1;
                    end
                    else if ((phase_reg == PH_LEAD1) && (s_tdata == CH_SPACE))
                    begin
                        phase_next = PH_LEAD1;
                    end
                    else if ((phase_reg == PH_LEAD1) && (s_tdata == CH_MINUS))
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_DIG1;
                    end
                    else
                    begin
                        first_next = acc_signed;
                        acc_next   = '0;
                        neg_next   = 1'b0;
                        if (s_tdata == CH_SPACE)
                        begin
                            phase_next = PH_GAP;
                        end
                        else
                        begin
                            opc_next   = s_tdata;
                            phase_next = PH_LEAD2;
                        end
                    end
                end
                PH_GAP:
                begin
                    if (s_tdata == CH_NUL)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (s_tdata != CH_SPACE)
                    begin
                        opc_next   = s_tdata;
                        phase_next = PH_LEAD2;
                    end
                end
                PH_LEAD2, PH_DIG2:
                begin
                    if (is_digit)
                    begin
                        acc_next   = acc_x10;
                        phase_next = PH_DIG2;
                    end
                    else if ((phase_reg == PH_LEAD2) && (s_tdata == CH_SPACE))
                    begin
                        phase_next = PH_LEAD2;
                    end
                    else if ((phase_reg == PH_LEAD2) && (s_tdata == CH_MINUS))
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_DIG2;
                    end
                    else
                    begin
                        acc_next   = acc_signed;
                        neg_next   = 1'b0;
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (accept && s_tlast)
        begin
            push            = 1'b1;
            job_a           = first_next;
            acc_signed_next = neg_next ? ({VALUE_WIDTH{1'b0}} - acc_next) : acc_next;
            if ((phase_next == PH_LEAD2) || (phase_next == PH_DIG2))
            begin
                job_b = acc_signed_next;
            end
            else if ((phase_next == PH_DONE) && (opc_next != CH_NUL))
            begin
                job_b = acc_next;
            end
            case (opc_next)
                CH_PLUS:  job_op = OP_ADD;
                CH_MINUS: job_op = OP_SUB;
                CH_STAR:  job_op = OP_MUL;
                CH_SLASH: job_op = OP_DIV;
                default:  job_op = OP_BAD;
            endcase
            phase_next = PH_LEAD1;
            first_next = '0;
            acc_next   = '0;
            neg_next   = 1'b0;
            opc_next   = CH_NUL;
            seen_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD1;
            first_reg <= '0;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            opc_reg   <= CH_NUL;
            seen_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            first_reg <= first_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            opc_reg   <= opc_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

// ===== hdl/iec_back.sv =====
// ============================================================================
// iec_back: arithmetic unit and output register
// Takes queued jobs, computes add and subtract in one step and multiply and
// divide bit-serially in a shared shift unit, and holds the result item.
// ============================================================================
module iec_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  iec_pkg::qstat_t                     qstat,
    output logic                                pop,
    input  iec_pkg::op_t                        job_op,
    input  logic [VALUE_WIDTH-1:0]              job_a,
    input  logic [VALUE_WIDTH-1:0]              job_b,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [iec_pkg::OUT_TDATA_W-1:0]     m_tdata  // [31:0] result_value,
                                                         // [33:32] status
);
    import iec_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    bk_state_t          state_reg;
    bk_state_t          state_next;
    logic [VW-1:0]      work_a_reg;
    logic [VW-1:0]      work_a_next;
    logic [VW-1:0]      work_b_reg;
    logic [VW-1:0]      work_b_next;
    logic [VW-1:0]      work_r_reg;
    logic [VW-1:0]      work_r_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               sneg_reg;
    logic               sneg_next;
    logic [VW-1:0]      res_reg;
    logic [VW-1:0]      res_next;
    logic [STATUS_W-1:0] st_reg;
    logic [STATUS_W-1:0] st_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [RESULT_W-1:0] out_value_reg;
    logic [RESULT_W-1:0] out_value_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] out_status_next;

    logic               out_free;
    logic               last_step;
    logic [VW:0]        rem_sh;
    logic [VW+1:0]      diff;
    logic               ge;
    logic [VW-1:0]      prod_sum;

    assign out_free  = !out_valid_reg || m_tready;
    assign last_step = (cnt_reg == CNT_W'(VALUE_WIDTH - 1));
    assign rem_sh    = {work_r_reg, work_a_reg[VW-1]};
    assign diff      = {1'b0, rem_sh} - {2'b00, work_b_reg};
    assign ge        = !diff[VW+1];
    assign prod_sum  = work_r_reg + (work_b_reg[0] ? work_a_reg : {VW{1'b0}});

    always_comb
    begin
        state_next      = state_reg;
        work_a_next     = work_a_reg;
        work_b_next     = work_b_reg;
        work_r_next     = work_r_reg;
        cnt_next        = cnt_reg;
        sneg_next       = sneg_reg;
        res_next        = res_reg;
        st_next         = st_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        pop             = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop         = 1'b1;
                    work_r_next = '0;
                    cnt_next    = '0;
                    st_next     = ST_OK;
                    state_next  = BK_DONE;
                    case (job_op)
                        OP_ADD: res_next = job_a + job_b;
                        OP_SUB: res_next = job_a - job_b;
                        OP_MUL:
                        begin
                            work_a_next = job_a;
                            work_b_next = job_b;
                            state_next  = BK_MUL;
                        end
                        OP_DIV:
                        begin
                            if (job_b == '0)
                            begin
                                res_next = '0;
                                st_next  = ST_DIV_ZERO;
                            end
                            else
                            begin
                                work_a_next = job_a[VW-1] ? ({VW{1'b0}} - job_a) : job_a;
                                work_b_next = job_b[VW-1] ? ({VW{1'b0}} - job_b) : job_b;
                                sneg_next   = job_a[VW-1] ^ job_b[VW-1];
                                state_next  = BK_DIV;
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                            st_next  = ST_BAD_OP;
                        end
                    endcase
                end
            end
            BK_MUL:
            begin
                work_r_next = prod_sum;
                work_a_next = work_a_reg << 1;
                work_b_next = work_b_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (last_step)
                begin
                    res_next   = prod_sum;
                    state_next = BK_DONE;
                end
            end
            BK_DIV:
            begin
                work_r_next = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
                work_a_next = {work_a_reg[VW-2:0], ge};
                cnt_next    = cnt_reg + 1'b1;
                if (last_step)
                begin
                    state_next = BK_FIX;
                end
            end
            BK_FIX:
            begin
                res_next   = sneg_reg ? ({VW{1'b0}} - work_a_reg) : work_a_reg;
                state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = RESULT_W'($signed(res_reg));
                    out_status_next = st_reg;
                    state_next      = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_a_reg     <= work_a_next;
        work_b_reg     <= work_b_next;
        work_r_reg     <= work_r_next;
        sneg_reg       <= sneg_next;
        res_reg        <= res_next;
        st_reg         <= st_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-RESULT_W-STATUS_W){1'b0}}, out_status_reg, out_value_reg};

endmodule

// ===== hdl/infix_expression_calculator_unit.sv =====
// ============================================================================
// infix_expression_calculator_unit: two-operand decimal expression calculator
// Parses a text line of the form "number operator number" one character per
// item and returns the sum, difference, product or quotient per line.
// ============================================================================
// Characters are taken at one per cycle; the input stalls only while the
// two-entry queue holds two lines. The end-of-line item queues the parsed
// line there, and the parser goes straight on with the next line. Add,
// subtract and errors are computed when the job leaves the queue and go
// through the result register to the output register; multiply and divide
// run in a shared bit-serial shift unit (divide with a further state for the
// sign), so the line rate is bounded by that unit when lines are short.
module infix_expression_calculator_unit #(
    parameter int LINE_LIMIT  = 60,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [iec_pkg::CHAR_W-1:0]        s_tdata,  // [7:0] char_code
    input  logic                              s_tlast,  // end_of_line
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [iec_pkg::OUT_TDATA_W-1:0]   m_tdata   // [31:0] result_value,
                                                        // [33:32] status
);
    import iec_pkg::*;

    localparam int JOB_W = OP_W + 2 * VALUE_WIDTH;

    qstat_t                  qstat;
    logic                    q_push;
    logic                    q_pop;
    op_t                     f_op;
    logic [VALUE_WIDTH-1:0]  f_a;
    logic [VALUE_WIDTH-1:0]  f_b;
    logic [JOB_W-1:0]        q_in;
    logic [JOB_W-1:0]        q_out;
    op_t                     b_op;

    iec_front #(
        .LINE_LIMIT  (LINE_LIMIT),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .qstat    (qstat),
        .push     (q_push),
        .job_op   (f_op),
        .job_a    (f_a),
        .job_b    (f_b)
    );

    assign q_in = {f_op, f_a, f_b};

    iec_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .qstat     (qstat)
    );

    assign b_op = op_t'(q_out[JOB_W-1 -: OP_W]);

    iec_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .pop      (q_pop),
        .job_op   (b_op),
        .job_a    (q_out[2*VALUE_WIDTH-1 -: VALUE_WIDTH]),
        .job_b    (q_out[VALUE_WIDTH-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !qstat.full)
        else $error("job queued while queue full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !qstat.empty)
        else $error("job taken from empty queue");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[33:32] != ST_OK)) |-> (m_tdata[31:0] == '0))
        else $error("error result carries nonzero value");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[33:32] != 2'd3))
        else $error("undefined status code");
`endif

endmodule
